FILE: hdl/tsh_pkg.sv
// tsh_pkg: types and constants shared by the triggered spike histogram blocks
// no dependencies; imported by the req and rsp interfaces and every module of the block
package tsh_pkg;

   localparam int FILL_W    = 14;   // window fill, sample and bin counters
   localparam int NBINS_W   = 7;    // bin count, up to 64
   localparam int DIV_STEPS = 14;   // quotient bits of the geometry divider
   localparam int OUT_CNT_W = 20;
   localparam int OUT_BIN_W = 6;
   localparam int OUT_TRL_W = 7;

   typedef enum logic [3:0] {
      REG_USE_ANALOG  = 4'd0,
      REG_TRIGGER_BIT = 4'd1,
      REG_THRESHOLD   = 4'd2,
      REG_RISING_EDGE = 4'd3,
      REG_PRE_SAMPLES = 4'd4,
      REG_POST_SAMPLES= 4'd5,
      REG_SAMPLES_BIN = 4'd6,
      REG_MAX_TRIALS  = 4'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      ACT_SAMPLE = 2'd0,
      ACT_DELETE = 2'd1,
      ACT_CLEAR  = 2'd2
   } action_type;

   typedef struct packed {
      logic               use_analog;
      logic [3:0]         trigger_bit;
      logic signed [15:0] analog_threshold;
      logic               rising_edge;
      logic [12:0]        pre_samples;
      logic [12:0]        post_samples;
      logic [13:0]        samples_per_bin;
      logic [6:0]         max_trials;
   } cfg_type;

   typedef struct packed {
      logic               ready;
      logic               valid;
      logic [FILL_W-1:0]  total;
      logic [NBINS_W-1:0] nbins;
   } geo_type;

   typedef struct packed {
      logic [1:0] action;
      logic       spike;
      logic       level;
   } cmd_type;

   typedef struct packed {
      logic [OUT_BIN_W-1:0] bin_index;
      logic [OUT_CNT_W-1:0] bin_count;
      logic [OUT_TRL_W-1:0] trial_count;
      logic                 last;
   } out_type;

endpackage

FILE: hdl/tsh_ifs.sv
// tsh_ifs: valid/ready channel interfaces of the triggered spike histogram
// depends on tsh_pkg
interface tsh_req_if;
   import tsh_pkg::*;
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic               spike;
   logic [15:0]        digital_word;
   logic signed [15:0] analog_sample;
   modport source(output valid, action, spike, digital_word, analog_sample, input ready);
   modport sink(input valid, action, spike, digital_word, analog_sample, output ready);
endinterface

interface tsh_rsp_if;
   import tsh_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [OUT_BIN_W-1:0] bin_index;
   logic [OUT_CNT_W-1:0] bin_count;
   logic [OUT_TRL_W-1:0] trial_count;
   logic                 last;
   modport source(output valid, bin_index, bin_count, trial_count, last, input ready);
   modport sink(input valid, bin_index, bin_count, trial_count, last, output ready);
endinterface

interface tsh_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [15:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

FILE: hdl/triggered_spike_histogram.sv
// triggered_spike_histogram: peri-stimulus spike histogram, top level
// depends on tsh_pkg, tsh_ifs, tsh_cfg, tsh_front, tsh_queue and tsh_back
//
// req_bus carries one item per sample (or a delete / clear action); rsp_bus
// returns one item per histogram bin, bin 0 first, last set on the final bin.
// csr_bus writes the eight setup registers by index; a write to one of them
// empties the window and all trials, and the geometry is then rechecked by a
// 14-step divider before the next item is taken from the queue. A sample that
// does not complete the window is only written to it in the back end; one that
// completes it but finds no edge moves the window on by one sample. A triggering
// sample walks the window sample by sample and bin by bin, after first dropping
// the oldest trial bin by bin if the store is at its trial limit, then emits one
// result per bin. A delete removes the newest trial bin by bin and then emits
// one result per bin. A two-entry queue lets the front take items while the back
// end works. A stalled rsp_bus holds the result register and the back end waits;
// nothing is dropped. Reset restores the register defaults and empties the
// window and the trial store; no clearing pass.
module triggered_spike_histogram #(
   parameter int WINDOW_DEPTH = 8192,
   parameter int MAX_BINS     = 64,
   parameter int TRIAL_SLOTS  = 64
) (
   input  logic      clock,
   input  logic      reset,
   tsh_req_if.sink   req_bus,
   tsh_rsp_if.source rsp_bus,
   tsh_csr_if.sink   csr_bus
);
   import tsh_pkg::*;

   cfg_type cfg;
   geo_type geo;
   cmd_type push_cmd, pop_cmd;
   logic    clear, push, full, pop, empty;

   tsh_cfg #(.WINDOW_DEPTH(WINDOW_DEPTH), .MAX_BINS(MAX_BINS)) u_cfg (
      .clock(clock), .reset(reset), .csr(csr_bus), .cfg(cfg), .geo(geo), .clear(clear)
   );

   tsh_front u_front (
      .req(req_bus), .cfg(cfg), .full(full), .push(push), .cmd(push_cmd)
   );

   tsh_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_cmd(push_cmd), .full(full),
      .pop(pop), .pop_cmd(pop_cmd), .empty(empty)
   );

   tsh_back #(
      .WINDOW_DEPTH(WINDOW_DEPTH), .MAX_BINS(MAX_BINS), .TRIAL_SLOTS(TRIAL_SLOTS)
   ) u_back (
      .clock(clock), .reset(reset), .cfg(cfg), .geo(geo), .clear(clear),
      .q_empty(empty), .q_cmd(pop_cmd), .pop(pop), .rsp(rsp_bus)
   );

endmodule

FILE: hdl/tsh_cfg.sv
// tsh_cfg: configuration registers and the iterative geometry check
// depends on tsh_pkg and tsh_csr_if
module tsh_cfg #(
   parameter int WINDOW_DEPTH = 8192,
   parameter int MAX_BINS     = 64
) (
   input  logic              clock,
   input  logic              reset,
   tsh_csr_if.sink           csr,
   output tsh_pkg::cfg_type  cfg,
   output tsh_pkg::geo_type  geo,
   output logic              clear
);
   import tsh_pkg::*;

   cfg_type           cfg_ff, cfg_in;
   logic              pend_ff, pend_in;
   logic              busy_ff, busy_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic [FILL_W:0]   rem_ff, rem_in;
   logic [FILL_W-1:0] quo_ff, quo_in;
   logic [FILL_W-1:0] total;
   logic [FILL_W:0]   trial;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;
   assign total     = {1'b0, cfg_ff.pre_samples} + {1'b0, cfg_ff.post_samples};

   always_comb begin
      cfg_in = cfg_ff;
      clear  = 1'b0;
      if (csr.valid) begin
         clear = 1'b1;
         unique case (csr.index)
            REG_USE_ANALOG:   cfg_in.use_analog       = csr.data[0];
            REG_TRIGGER_BIT:  cfg_in.trigger_bit      = csr.data[3:0];
            REG_THRESHOLD:    cfg_in.analog_threshold = csr.data;
            REG_RISING_EDGE:  cfg_in.rising_edge      = csr.data[0];
            REG_PRE_SAMPLES:  cfg_in.pre_samples      = csr.data[12:0];
            REG_POST_SAMPLES: cfg_in.post_samples     = csr.data[12:0];
            REG_SAMPLES_BIN:  cfg_in.samples_per_bin  = csr.data[13:0];
            REG_MAX_TRIALS:   cfg_in.max_trials       = csr.data[6:0];
            default:          clear = 1'b0;
         endcase
      end
   end

   // restoring divide of the window length by the bin size, one bit a cycle
   always_comb begin
      pend_in = pend_ff | clear;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      trial   = {rem_ff[FILL_W-1:0], quo_ff[FILL_W-1]};
      if (pend_ff) begin
         pend_in = clear;
         busy_in = 1'b1;
         cnt_in  = 4'(DIV_STEPS);
         rem_in  = '0;
         quo_in  = total;
      end else if (busy_ff) begin
         if (trial >= {1'b0, cfg_ff.samples_per_bin}) begin
            rem_in = trial - {1'b0, cfg_ff.samples_per_bin};
            quo_in = {quo_ff[FILL_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[FILL_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 4'd1;
         if (cnt_ff == 4'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.use_analog       <= 1'b0;
         cfg_ff.trigger_bit      <= '0;
         cfg_ff.analog_threshold <= '0;
         cfg_ff.rising_edge      <= 1'b1;
         cfg_ff.pre_samples      <= 13'd1;
         cfg_ff.post_samples     <= 13'd1;
         cfg_ff.samples_per_bin  <= 14'd1;
         cfg_ff.max_trials       <= 7'd64;
         pend_ff                 <= 1'b1;
         busy_ff                 <= 1'b0;
         cnt_ff                  <= '0;
      end else begin
         cfg_ff  <= cfg_in;
         pend_ff <= pend_in;
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign geo.ready = !pend_ff && !busy_ff;
   assign geo.total = total;
   assign geo.nbins = NBINS_W'(quo_ff);
   assign geo.valid = (cfg_ff.pre_samples != '0) && (cfg_ff.post_samples != '0)
                   && (32'(total) <= WINDOW_DEPTH) && (cfg_ff.samples_per_bin != '0)
                   && (rem_ff == '0) && (32'(quo_ff) <= MAX_BINS);

endmodule

FILE: hdl/tsh_front.sv
// tsh_front: accepts request items and works out the trigger level
// depends on tsh_pkg and tsh_req_if
module tsh_front (
   tsh_req_if.sink          req,
   input  tsh_pkg::cfg_type cfg,
   input  logic             full,
   output logic             push,
   output tsh_pkg::cmd_type cmd
);
   import tsh_pkg::*;

   assign req.ready  = !full;
   assign push       = req.valid && !full;
   assign cmd.action = req.action;
   assign cmd.spike  = req.spike;
   assign cmd.level  = cfg.use_analog ? (req.analog_sample >= cfg.analog_threshold)
                                      : req.digital_word[cfg.trigger_bit];

endmodule

FILE: hdl/tsh_queue.sv
// tsh_queue: two-entry command queue between front and back
// depends on tsh_pkg
module tsh_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tsh_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output tsh_pkg::cmd_type pop_cmd,
   output logic             empty
);
   import tsh_pkg::*;

   cmd_type    slot_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign pop_cmd = slot_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff ^ push;
      rptr_in  = rptr_ff ^ pop;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) slot_ff[wptr_ff] <= push_cmd;
   end

endmodule

FILE: hdl/tsh_back.sv
// tsh_back: sample window, trial store and bin totals, with the result register
// depends on tsh_pkg and tsh_rsp_if
module tsh_back #(
   parameter int WINDOW_DEPTH = 8192,
   parameter int MAX_BINS     = 64,
   parameter int TRIAL_SLOTS  = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  tsh_pkg::cfg_type cfg,
   input  tsh_pkg::geo_type geo,
   input  logic             clear,
   input  logic             q_empty,
   input  tsh_pkg::cmd_type q_cmd,
   output logic             pop,
   tsh_rsp_if.source        rsp
);
   import tsh_pkg::*;

   localparam int AW     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int SW     = (TRIAL_SLOTS > 1) ? $clog2(TRIAL_SLOTS) : 1;
   localparam int KW     = $clog2(TRIAL_SLOTS + 1);
   localparam int BW     = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int TW     = KW + FILL_W;
   localparam int SUMW   = ((AW > FILL_W) ? AW : FILL_W) + 1;
   localparam int SDEPTH = TRIAL_SLOTS * (2 ** BW);

   typedef enum logic [12:0] {
      S_IDLE     = 13'b0000000000001,
      S_TRG_A    = 13'b0000000000010,
      S_TRG_B    = 13'b0000000000100,
      S_TRG_C    = 13'b0000000001000,
      S_REM_RD   = 13'b0000000010000,
      S_REM_WR   = 13'b0000000100000,
      S_ADD_INIT = 13'b0000001000000,
      S_WALK_RD  = 13'b0000010000000,
      S_WALK_ACC = 13'b0000100000000,
      S_BIN_RD   = 13'b0001000000000,
      S_BIN_WR   = 13'b0010000000000,
      S_EMIT_RD  = 13'b0100000000000,
      S_EMIT_WR  = 13'b1000000000000
   } state_type;

   state_type         state_ff, state_in;
   logic [AW-1:0]     head_ff, head_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [KW-1:0]     kept_ff, kept_in;
   logic [SW-1:0]     oldest_ff, oldest_in;
   logic [SW-1:0]     slot_ff, slot_in;
   logic              adding_ff, adding_in;
   logic              prev_ff, prev_in;
   logic [BW-1:0]     bin_ff, bin_in;
   logic [AW-1:0]     ptr_ff, ptr_in;
   logic [FILL_W-1:0] inbin_ff, inbin_in;
   logic [FILL_W-1:0] cnt_ff, cnt_in;
   logic [MAX_BINS-1:0] tvld_ff, tvld_in;
   logic              rsp_vld_ff, rsp_vld_in;
   out_type           rsp_ff, rsp_in;

   logic [1:0]        win_mem [WINDOW_DEPTH];
   logic              win_we;
   logic [AW-1:0]     win_waddr, win_raddr;
   logic [1:0]        win_wdata, win_rd_ff;

   logic [FILL_W-1:0] sto_mem [SDEPTH];
   logic              sto_we;
   logic [FILL_W-1:0] sto_rd_ff;

   logic [TW-1:0]     tot_mem [MAX_BINS];
   logic              tot_we;
   logic [TW-1:0]     tot_wdata, tot_rd_ff, tot_val;
   logic              tvld_rd_ff;

   logic              last_bin, out_free, trig;
   logic [FILL_W-1:0] cnt_sum;
   logic [TW+OUT_CNT_W-1:0] tot_ext;
   int unsigned       limit;

   function automatic logic [AW-1:0] win_wrap(input logic [AW-1:0] base,
                                               input logic [FILL_W-1:0] off);
      logic [SUMW-1:0] s;
      s = SUMW'(base) + SUMW'(off);
      if (s >= SUMW'(WINDOW_DEPTH)) s = s - SUMW'(WINDOW_DEPTH);
      return AW'(s);
   endfunction

   function automatic logic [SW-1:0] slot_add(input logic [SW-1:0] base,
                                               input logic [KW-1:0] off);
      logic [KW:0] s;
      s = (KW+1)'(base) + (KW+1)'(off);
      if (s >= (KW+1)'(TRIAL_SLOTS)) s = s - (KW+1)'(TRIAL_SLOTS);
      return SW'(s);
   endfunction

   assign tot_val  = tvld_rd_ff ? tot_rd_ff : '0;
   assign last_bin = (NBINS_W'(bin_ff) + NBINS_W'(1)) == geo.nbins;
   assign out_free = !rsp_vld_ff || rsp.ready;
   assign cnt_sum  = cnt_ff + FILL_W'(win_rd_ff[0]);
   assign trig     = (prev_ff != win_rd_ff[1]) && (cfg.rising_edge == win_rd_ff[1]);
   assign tot_ext  = (TW+OUT_CNT_W)'(tot_val);

   always_comb begin
      if (cfg.max_trials == '0) limit = 1;
      else if (32'(cfg.max_trials) > TRIAL_SLOTS) limit = TRIAL_SLOTS;
      else limit = 32'(cfg.max_trials);
   end

   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      fill_in    = fill_ff;
      kept_in    = kept_ff;
      oldest_in  = oldest_ff;
      slot_in    = slot_ff;
      adding_in  = adding_ff;
      prev_in    = prev_ff;
      bin_in     = bin_ff;
      ptr_in     = ptr_ff;
      inbin_in   = inbin_ff;
      cnt_in     = cnt_ff;
      tvld_in    = tvld_ff;
      rsp_vld_in = rsp_vld_ff && !rsp.ready;
      rsp_in     = rsp_ff;
      pop        = 1'b0;
      win_we     = 1'b0;
      win_waddr  = win_wrap(head_ff, fill_ff);
      win_wdata  = {q_cmd.level, q_cmd.spike};
      win_raddr  = ptr_ff;
      sto_we     = 1'b0;
      tot_we     = 1'b0;
      tot_wdata  = tot_val + TW'(cnt_ff);

      if (clear) begin
         state_in  = S_IDLE;
         head_in   = '0;
         fill_in   = '0;
         kept_in   = '0;
         oldest_in = '0;
         tvld_in   = '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (!q_empty && geo.ready) begin
                  pop = 1'b1;
                  bin_in = '0;
                  if (q_cmd.action == ACT_CLEAR) begin
                     head_in   = '0;
                     fill_in   = '0;
                     kept_in   = '0;
                     oldest_in = '0;
                     tvld_in   = '0;
                  end else if (q_cmd.action == ACT_DELETE) begin
                     if (kept_ff != '0 && geo.valid) begin
                        kept_in   = kept_ff - KW'(1);
                        slot_in   = slot_add(oldest_ff, kept_ff - KW'(1));
                        adding_in = 1'b0;
                        state_in  = S_REM_RD;
                     end
                  end else if (q_cmd.action == ACT_SAMPLE && geo.valid) begin
                     win_we  = 1'b1;
                     fill_in = fill_ff + FILL_W'(1);
                     if (fill_ff + FILL_W'(1) >= geo.total) state_in = S_TRG_A;
                  end
               end
            end
            S_TRG_A: begin
               win_raddr = win_wrap(head_ff, FILL_W'(cfg.pre_samples) - FILL_W'(1));
               state_in  = S_TRG_B;
            end
            S_TRG_B: begin
               win_raddr = win_wrap(head_ff, FILL_W'(cfg.pre_samples));
               prev_in   = win_rd_ff[1];
               state_in  = S_TRG_C;
            end
            S_TRG_C: begin
               if (!trig) begin
                  head_in  = win_wrap(head_ff, FILL_W'(1));
                  fill_in  = fill_ff - FILL_W'(1);
                  state_in = S_IDLE;
               end else if (32'(kept_ff) >= limit && kept_ff != '0) begin
                  // trial limit reached, so drop the oldest trial before adding
                  slot_in   = oldest_ff;
                  adding_in = 1'b1;
                  state_in  = S_REM_RD;
               end else begin
                  state_in = S_ADD_INIT;
               end
            end
            S_REM_RD: state_in = S_REM_WR;
            S_REM_WR: begin
               tot_we    = 1'b1;
               tot_wdata = (tot_val >= TW'(sto_rd_ff)) ? tot_val - TW'(sto_rd_ff) : '0;
               tvld_in[bin_ff] = 1'b1;
               if (last_bin) begin
                  bin_in = '0;
                  if (adding_ff) begin
                     oldest_in = (oldest_ff == SW'(TRIAL_SLOTS - 1)) ? '0
                                                                     : oldest_ff + SW'(1);
                     kept_in   = kept_ff - KW'(1);
                     state_in  = S_ADD_INIT;
                  end else begin
                     state_in = S_EMIT_RD;
                  end
               end else begin
                  bin_in   = bin_ff + BW'(1);
                  state_in = S_REM_RD;
               end
            end
            S_ADD_INIT: begin
               slot_in  = slot_add(oldest_ff, kept_ff);
               ptr_in   = head_ff;
               bin_in   = '0;
               cnt_in   = '0;
               inbin_in = '0;
               state_in = S_WALK_RD;
            end
            S_WALK_RD: state_in = S_WALK_ACC;
            S_WALK_ACC: begin
               cnt_in = cnt_sum;
               ptr_in = (ptr_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : ptr_ff + AW'(1);
               if (inbin_ff + FILL_W'(1) == cfg.samples_per_bin) begin
                  state_in = S_BIN_RD;
               end else begin
                  inbin_in = inbin_ff + FILL_W'(1);
                  state_in = S_WALK_RD;
               end
            end
            S_BIN_RD: begin
               sto_we   = 1'b1;
               state_in = S_BIN_WR;
            end
            S_BIN_WR: begin
               tot_we   = 1'b1;
               tvld_in[bin_ff] = 1'b1;
               cnt_in   = '0;
               inbin_in = '0;
               if (last_bin) begin
                  kept_in  = kept_ff + KW'(1);
                  head_in  = win_wrap(head_ff, FILL_W'(cfg.post_samples));
                  fill_in  = fill_ff - FILL_W'(cfg.post_samples);
                  bin_in   = '0;
                  state_in = S_EMIT_RD;
               end else begin
                  bin_in   = bin_ff + BW'(1);
                  state_in = S_WALK_RD;
               end
            end
            S_EMIT_RD: state_in = S_EMIT_WR;
            S_EMIT_WR: begin
               if (out_free) begin
                  rsp_vld_in         = 1'b1;
                  rsp_in.bin_index   = OUT_BIN_W'(bin_ff);
                  rsp_in.bin_count   = (tot_ext > (TW+OUT_CNT_W)'({OUT_CNT_W{1'b1}}))
                                       ? {OUT_CNT_W{1'b1}} : OUT_CNT_W'(tot_val);
                  rsp_in.trial_count = OUT_TRL_W'(kept_ff);
                  rsp_in.last        = last_bin;
                  if (last_bin) begin
                     state_in = S_IDLE;
                  end else begin
                     bin_in   = bin_ff + BW'(1);
                     state_in = S_EMIT_RD;
                  end
               end
            end
            default: state_in = S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         head_ff    <= '0;
         fill_ff    <= '0;
         kept_ff    <= '0;
         oldest_ff  <= '0;
         tvld_ff    <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         head_ff    <= head_in;
         fill_ff    <= fill_in;
         kept_ff    <= kept_in;
         oldest_ff  <= oldest_in;
         tvld_ff    <= tvld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      slot_ff   <= slot_in;
      adding_ff <= adding_in;
      prev_ff   <= prev_in;
      bin_ff    <= bin_in;
      ptr_ff    <= ptr_in;
      inbin_ff  <= inbin_in;
      cnt_ff    <= cnt_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (win_we) win_mem[win_waddr] <= win_wdata;
      win_rd_ff <= win_mem[win_raddr];
   end

   always_ff @(posedge clock) begin
      if (sto_we) sto_mem[{slot_ff, bin_ff}] <= cnt_ff;
      sto_rd_ff <= sto_mem[{slot_ff, bin_ff}];
   end

   always_ff @(posedge clock) begin
      if (tot_we) tot_mem[bin_ff] <= tot_wdata;
      tot_rd_ff  <= tot_mem[bin_ff];
      tvld_rd_ff <= tvld_ff[bin_ff];
   end

   assign rsp.valid       = rsp_vld_ff;
   assign rsp.bin_index   = rsp_ff.bin_index;
   assign rsp.bin_count   = rsp_ff.bin_count;
   assign rsp.trial_count = rsp_ff.trial_count;
   assign rsp.last        = rsp_ff.last;

endmodule

FILE: sim/triggered_spike_histogram_tb.sv
// triggered_spike_histogram_tb: self-checking bench for the spike histogram top level
// depends on tsh_pkg, tsh_ifs and the triggered_spike_histogram rtl
// drives items and register writes, predicts bin results in-bench, checks every result
module triggered_spike_histogram_tb;
   import tsh_pkg::*;

   localparam int DEPTH       = 8192;
   localparam int BINS        = 64;
   localparam int SLOTS       = 64;
   localparam int STALL_LIMIT = 200000;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   logic clock;
   logic reset;

   tsh_req_if req_bus();
   tsh_rsp_if rsp_bus();
   tsh_csr_if csr_bus();

   triggered_spike_histogram uut (
      .clock(clock), .reset(reset),
      .req_bus(req_bus), .rsp_bus(rsp_bus), .csr_bus(csr_bus)
   );

   // predictor state
   cfg_type     shadow;
   logic [1:0]  win_mem [DEPTH];
   int unsigned win_head, win_fill;
   logic [15:0] trial_cnt [SLOTS][BINS];
   int unsigned bin_sum [BINS];
   int unsigned kept, oldest;
   out_type     pending_bins [$];

   int  errors, items_sent, bins_checked, trials_seen, stall_count;
   bit  no_gaps;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic bit geometry_ok(output int unsigned total, output int unsigned nbins);
      int unsigned t;
      t = shadow.pre_samples + shadow.post_samples;
      total = t;
      nbins = 0;
      if (shadow.pre_samples == 0 || shadow.post_samples == 0 || t > DEPTH) return 0;
      if (shadow.samples_per_bin == 0 || t % shadow.samples_per_bin != 0) return 0;
      if (t / shadow.samples_per_bin > BINS) return 0;
      nbins = t / shadow.samples_per_bin;
      return 1;
   endfunction

   function automatic void wipe_store();
      win_head = 0;
      win_fill = 0;
      kept = 0;
      oldest = 0;
      foreach (bin_sum[b]) bin_sum[b] = 0;
   endfunction

   function automatic void drop_slot(int unsigned slot);
      for (int b = 0; b < BINS; b++) begin
         bin_sum[b] = (bin_sum[b] >= trial_cnt[slot][b]) ? bin_sum[b] - trial_cnt[slot][b] : 0;
         trial_cnt[slot][b] = '0;
      end
   endfunction

   function automatic void queue_bins(int unsigned nbins);
      out_type o;
      for (int unsigned k = 0; k < nbins; k++) begin
         o.bin_index   = k[5:0];
         o.bin_count   = (bin_sum[k] > 20'hFFFFF) ? 20'hFFFFF : bin_sum[k][19:0];
         o.trial_count = kept[6:0];
         o.last        = (k + 1 == nbins);
         pending_bins  = {pending_bins, o};
      end
   endfunction

   function automatic void histogram_step(logic [1:0] act, logic spk, logic [15:0] word,
                                          logic [15:0] ana);
      int unsigned total, nbins, slot, limit;
      bit ok;
      logic lvl, prev, cur;
      ok = geometry_ok(total, nbins);
      if (act == ACT_CLEAR) begin
         wipe_store();
         return;
      end
      if (act == ACT_DELETE) begin
         if (kept == 0 || !ok) return;
         kept--;
         drop_slot((oldest + kept) % SLOTS);
         queue_bins(nbins);
         return;
      end
      if (act != ACT_SAMPLE || !ok) return;
      lvl = shadow.use_analog ? ($signed(ana) >= shadow.analog_threshold)
                              : word[shadow.trigger_bit];
      win_mem[(win_head + win_fill) % DEPTH] = {lvl, spk};
      win_fill++;
      if (win_fill < total) return;
      prev = win_mem[(win_head + shadow.pre_samples - 1) % DEPTH][1];
      cur  = win_mem[(win_head + shadow.pre_samples) % DEPTH][1];
      if (prev == cur || cur != shadow.rising_edge) begin
         win_head = (win_head + 1) % DEPTH;
         win_fill--;
         return;
      end
      // new trial, evicting the oldest when the store is at its limit
      limit = (shadow.max_trials == 0) ? 1
            : (shadow.max_trials > SLOTS) ? SLOTS : shadow.max_trials;
      if (kept >= limit && kept > 0) begin
         drop_slot(oldest);
         oldest = (oldest + 1) % SLOTS;
         kept--;
      end
      slot = (oldest + kept) % SLOTS;
      for (int b = 0; b < BINS; b++) trial_cnt[slot][b] = '0;
      for (int unsigned k = 0; k < total; k++)
         if (win_mem[(win_head + k) % DEPTH][0]) begin
            trial_cnt[slot][k / shadow.samples_per_bin]++;
            bin_sum[k / shadow.samples_per_bin]++;
         end
      kept++;
      trials_seen++;
      win_head = (win_head + shadow.post_samples) % DEPTH;
      win_fill -= shadow.post_samples;
      queue_bins(nbins);
   endfunction

   task automatic maybe_idle(output bit idled);
      idled = 0;
      if (!no_gaps && $urandom_range(99) < 26) begin
         idled = 1;
         repeat ($urandom_range(3, 1)) @(negedge clock);
      end
   endtask

   task automatic send_item(logic [1:0] act, logic spk, logic [15:0] word, logic [15:0] ana);
      bit idled;
      req_bus.valid = 1'b0;
      maybe_idle(idled);
      req_bus.action        = act;
      req_bus.spike         = spk;
      req_bus.digital_word  = word;
      req_bus.analog_sample = ana;
      req_bus.valid         = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      histogram_step(act, spk, word, ana);
      items_sent++;
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   // wait for every expected bin, then give any silent items time to finish
   task automatic drain_all();
      int unsigned total, nbins, settle;
      settle = geometry_ok(total, nbins) ? 3 * (2 * total + 8 * BINS) + 100 : 200;
      while (pending_bins.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [15:0] value);
      csr_bus.index = idx;
      csr_bus.data  = value;
      csr_bus.valid = 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         REG_USE_ANALOG:   shadow.use_analog       = value[0];
         REG_TRIGGER_BIT:  shadow.trigger_bit      = value[3:0];
         REG_THRESHOLD:    shadow.analog_threshold = value;
         REG_RISING_EDGE:  shadow.rising_edge      = value[0];
         REG_PRE_SAMPLES:  shadow.pre_samples      = value[12:0];
         REG_POST_SAMPLES: shadow.post_samples     = value[12:0];
         REG_SAMPLES_BIN:  shadow.samples_per_bin  = value[13:0];
         REG_MAX_TRIALS:   shadow.max_trials       = value[6:0];
         default: ;
      endcase
      wipe_store();
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // result side: random back-pressure (none while no_gaps is set), compare with the oldest expected bin
   initial begin
      out_type want;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready = no_gaps || ($urandom_range(99) >= 26);
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_bins.size() == 0) begin
               $display("%0t: unexpected item bin %0d count %0d", $time,
                        rsp_bus.bin_index, rsp_bus.bin_count);
               errors++;
            end else begin
               want = pending_bins[0];
               pending_bins.delete(0);
               bins_checked++;
               if (rsp_bus.bin_index !== want.bin_index) begin
                  $display("%0t: bin_index expected %0d actual %0d", $time,
                           want.bin_index, rsp_bus.bin_index);
                  errors++;
               end
               if (rsp_bus.bin_count !== want.bin_count) begin
                  $display("%0t: bin_count expected %0d actual %0d", $time,
                           want.bin_count, rsp_bus.bin_count);
                  errors++;
               end
               if (rsp_bus.trial_count !== want.trial_count) begin
                  $display("%0t: trial_count expected %0d actual %0d", $time,
                           want.trial_count, rsp_bus.trial_count);
                  errors++;
               end
               if (rsp_bus.last !== want.last) begin
                  $display("%0t: last expected %0d actual %0d", $time,
                           want.last, rsp_bus.last);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready))
         stall_count <= 0;
      else if (stall_count >= STALL_LIMIT) begin
         $display("%0t: watchdog, nothing moved for %0d cycles", $time, STALL_LIMIT);
         $display("triggered_spike_histogram_tb: done, errors");
         $finish;
      end else
         stall_count <= stall_count + 1;
   end

   task automatic test_digital_defaults();
      // pre 1 post 1 one bin each, trigger on rising bit 0
      send_item(ACT_SAMPLE, 1, 16'h0000, 16'h0000);
      send_item(ACT_SAMPLE, 1, 16'h0001, 16'h7FFF);
      send_item(ACT_SAMPLE, 0, 16'hFFFE, 16'h8000);
      send_item(ACT_SAMPLE, 1, 16'hFFFF, 16'h0000);
      send_item(ACT_SAMPLE, 1, 16'h0000, 16'hFFFF);
      send_item(ACT_SAMPLE, 0, 16'h0001, 16'h0001);
      send_item(ACT_DELETE, 0, 16'h0000, 16'h0000);
      send_item(ACT_DELETE, 1, 16'hFFFF, 16'hFFFF);
      send_item(ACT_DELETE, 0, 16'h0000, 16'h0000);
      send_item(ACT_DELETE, 0, 16'h0000, 16'h0000);   // none left
      send_item(ACT_SAMPLE, 1, 16'h0000, 16'h0000);
      send_item(ACT_SAMPLE, 1, 16'h0001, 16'h0000);
      send_item(ACT_UNUSED, 1, 16'hFFFF, 16'h8000);
      send_item(ACT_CLEAR, 1, 16'h5555, 16'hAAAA);
      send_item(ACT_SAMPLE, 1, 16'h0001, 16'h0000);
      drain_all();
   endtask

   task automatic test_analog_threshold();
      write_reg(REG_USE_ANALOG, 16'd1);
      write_reg(REG_TRIGGER_BIT, 16'd15);
      write_reg(REG_RISING_EDGE, 16'd0);
      write_reg(REG_THRESHOLD, 16'h8000);    // always high, no edge
      send_item(ACT_SAMPLE, 1, 16'h0000, 16'h8000);
      send_item(ACT_SAMPLE, 1, 16'hFFFF, 16'h7FFF);
      drain_all();
      write_reg(REG_THRESHOLD, 16'h7FFF);
      send_item(ACT_SAMPLE, 1, 16'h0000, 16'h7FFF);
      send_item(ACT_SAMPLE, 1, 16'h0000, 16'h8000);  // falling
      send_item(ACT_SAMPLE, 0, 16'h0000, 16'h7FFE);
      drain_all();
      write_reg(REG_USE_ANALOG, 16'd0);
      write_reg(REG_RISING_EDGE, 16'd1);
      send_item(ACT_SAMPLE, 1, 16'h0000, 16'h0000);
      send_item(ACT_SAMPLE, 1, 16'h8000, 16'h0000);
      drain_all();
   endtask

   task automatic test_random_trials(int n_items, bit drain_midway);
      int unsigned pre, post, spb, total, run_len;
      int divs [$];
      logic lvl;
      pre  = $urandom_range(12, 1);
      post = $urandom_range(12, 1);
      total = pre + post;
      for (int d = 1; d <= total; d++) if (total % d == 0) divs = {divs, d};
      spb = divs[$urandom_range(divs.size() - 1)];
      write_reg(REG_USE_ANALOG, 16'($urandom_range(1)));
      write_reg(REG_TRIGGER_BIT, 16'($urandom_range(15)));
      write_reg(REG_THRESHOLD, 16'($urandom_range(16'hFFFF)));
      write_reg(REG_RISING_EDGE, 16'($urandom_range(1)));
      write_reg(REG_PRE_SAMPLES, 16'(pre));
      write_reg(REG_POST_SAMPLES, 16'(post));
      write_reg(REG_SAMPLES_BIN, 16'(spb));
      write_reg(REG_MAX_TRIALS, 16'($urandom_range(4, 1)));
      lvl = 0;
      run_len = 0;
      for (int i = 0; i < n_items; i++) begin
         int unsigned pick;
         logic [15:0] word, ana;
         // trigger level held in runs so edges land at the pre-trigger point
         if (run_len == 0) begin
            lvl = ~lvl;
            run_len = $urandom_range(2 * total, 1);
         end
         run_len--;
         word = 16'($urandom_range(16'hFFFF));
         ana  = 16'($urandom_range(16'hFFFF));
         word[shadow.trigger_bit] = lvl;
         if (shadow.use_analog) ana = lvl ? 16'h7FFF : 16'h8000;
         if (shadow.use_analog && lvl && shadow.analog_threshold == 16'sh7FFF && $urandom_range(1))
            ana = 16'h7FFF;
         pick = $urandom_range(99);
         if (drain_midway && i == n_items / 2) drain_all();
         if (pick < 8)
            send_item(ACT_DELETE, 1'($urandom_range(1)), word, ana);
         else if (pick < 10)
            send_item(ACT_CLEAR, 1'($urandom_range(1)), word, ana);
         else if (pick < 12)
            send_item(ACT_UNUSED, 1'($urandom_range(1)), word, ana);
         else if (pick < 16)
            send_item(ACT_SAMPLE, 1'($urandom_range(1)), 16'($urandom_range(16'hFFFF)),
                      16'($urandom_range(16'hFFFF)));
         else
            send_item(ACT_SAMPLE, 1'($urandom_range(1)), word, ana);
      end
      drain_all();
   endtask

   task automatic test_extreme_settings();
      // oversized window, zero and oversized bin size, trial limits out of range
      write_reg(REG_PRE_SAMPLES, 16'd8191);
      write_reg(REG_POST_SAMPLES, 16'd8191);
      send_item(ACT_SAMPLE, 1, 16'hFFFF, 16'h0000);
      send_item(ACT_DELETE, 1, 16'hFFFF, 16'h0000);
      drain_all();
      write_reg(REG_PRE_SAMPLES, 16'd1);
      write_reg(REG_POST_SAMPLES, 16'd1);
      write_reg(REG_SAMPLES_BIN, 16'd0);
      send_item(ACT_SAMPLE, 1, 16'h0000, 16'h0000);
      send_item(ACT_SAMPLE, 1, 16'hFFFF, 16'h0000);
      drain_all();
      write_reg(REG_SAMPLES_BIN, 16'd8192);
      send_item(ACT_SAMPLE, 1, 16'h0000, 16'h0000);
      drain_all();
      write_reg(REG_SAMPLES_BIN, 16'd2);
      write_reg(REG_MAX_TRIALS, 16'd0);
      write_reg(REG_TRIGGER_BIT, 16'd0);
      for (int i = 0; i < 6; i++) send_item(ACT_SAMPLE, 1, i[0] ? 16'h0001 : 16'h0000, 16'h0);
      drain_all();
      write_reg(REG_MAX_TRIALS, 16'd127);
      for (int i = 0; i < 12; i++) send_item(ACT_SAMPLE, i[1], i[0] ? 16'h0001 : 16'h0000, 16'h0);
      drain_all();
   endtask

   initial begin
      errors = 0;
      items_sent = 0;
      bins_checked = 0;
      trials_seen = 0;
      stall_count = 0;
      no_gaps = 0;
      req_bus.valid = 1'b0;
      req_bus.action = ACT_SAMPLE;
      req_bus.spike = 1'b0;
      req_bus.digital_word = '0;
      req_bus.analog_sample = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = REG_USE_ANALOG;
      csr_bus.data = '0;
      shadow = '{use_analog: 1'b0, trigger_bit: 4'd0, analog_threshold: 16'sd0,
                 rising_edge: 1'b1, pre_samples: 13'd1, post_samples: 13'd1,
                 samples_per_bin: 14'd1, max_trials: 7'd64};
      wipe_store();
      reset = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_digital_defaults();
      test_analog_threshold();
      test_random_trials(120, 1);
      no_gaps = 1;
      test_random_trials(80, 0);
      no_gaps = 0;
      test_random_trials(120, 0);
      test_random_trials(90, 1);
      test_extreme_settings();

      $display("covered %0d items, %0d trials, %0d bins checked", items_sent, trials_seen,
               bins_checked);
      $display("digital and analog triggers, both edges, deletes, clears, trial eviction");
      if (errors == 0)
         $display("triggered_spike_histogram_tb: done, clean");
      else
         $display("triggered_spike_histogram_tb: done, errors");
      $finish;
   end

endmodule

FILE: triggered_spike_histogram.f
hdl/tsh_pkg.sv
hdl/tsh_ifs.sv
hdl/tsh_cfg.sv
hdl/tsh_front.sv
hdl/tsh_queue.sv
hdl/tsh_back.sv
hdl/triggered_spike_histogram.sv
sim/triggered_spike_histogram_tb.sv
